[rtl/rcmm_pkg.sv]
// ----------------------------------------------------------------------------
// rcmm_pkg: shared types and constants
// Field widths, register indexes and the control struct that drives the
// row of count cells.
// ----------------------------------------------------------------------------
package rcmm_pkg;

    // payload widths
    localparam int ELEM_W     = 32;
    localparam int ROW_IDX_W  = 6;
    localparam int COUNT_W    = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 8;

    // size limits
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 8'd1;

    // count saturation and minimum reset value
    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'h7F;
    localparam logic signed [ELEM_W-1:0] MIN_RESET = 32'sh7FFF_FFFF;

    // control broadcast to every cell
    typedef struct packed {
        logic                 clear;  // zero all counts
        logic                 shift;  // move counts one cell towards the output
        logic                 less;   // new strict minimum
        logic                 equal;  // element equals the minimum
        logic [ROW_IDX_W-1:0] row;    // row of the current element
    } cell_ctrl_t;

endpackage

[rtl/rcmm_if.sv]
// ----------------------------------------------------------------------------
// rcmm interfaces: element, result and configuration channels
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------

// element stream
interface rcmm_elem_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [rcmm_pkg::ELEM_W-1:0]        element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

// per-row results
interface rcmm_result_if;
    logic                                      valid;
    logic                                      ready;
    logic [rcmm_pkg::ROW_IDX_W-1:0]            row_index;
    logic [rcmm_pkg::COUNT_W-1:0]              min_count;
    logic                                      last_row;

    modport source (output valid, output row_index, output min_count,
                    output last_row, input ready);
    modport sink   (input valid, input row_index, input min_count,
                    input last_row, output ready);
endinterface

// register writes
interface rcmm_cfg_if;
    logic                                      valid;
    logic                                      ready;
    logic [rcmm_pkg::CFG_IDX_W-1:0]            index;
    logic [rcmm_pkg::CFG_DATA_W-1:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/rcmm_cell.sv]
// ----------------------------------------------------------------------------
// rcmm_cell: one row count
// Holds the minimum count of one row; updates on element events and hands
// its count to the neighbour nearer the output while the results drain.
// ----------------------------------------------------------------------------
module rcmm_cell #(
    parameter int IDX = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rcmm_pkg::cell_ctrl_t                ctrl,
    input  logic [rcmm_pkg::COUNT_W-1:0]        count_in,
    output logic [rcmm_pkg::COUNT_W-1:0]        count_out
);

    localparam logic [rcmm_pkg::ROW_IDX_W-1:0] MY_ROW = rcmm_pkg::ROW_IDX_W'(IDX);

    logic [rcmm_pkg::COUNT_W-1:0] count_reg;
    logic [rcmm_pkg::COUNT_W-1:0] count_next;
    logic                         sel;

    assign sel = (ctrl.row == MY_ROW);

    // count update
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (ctrl.shift)
        begin
            count_next = count_in;
        end
        else if (ctrl.less)
        begin
            count_next = sel ? rcmm_pkg::COUNT_W'(1) : '0;
        end
        else if (ctrl.equal && sel && (count_reg != rcmm_pkg::COUNT_MAX))
        begin
            count_next = count_reg + rcmm_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count_out = count_reg;

endmodule

[rtl/row_count_of_matrix_minimum_unit.sv]
// ----------------------------------------------------------------------------
// row_count_of_matrix_minimum_unit: per-row counts of the global minimum
// Streams a signed matrix in row-major order and reports, per row, how often
// the global minimum occurs.
// ----------------------------------------------------------------------------
// Usage
//   cfg  : register writes, index 0 = num_rows, index 1 = num_cols (1..64).
//          Any write to a known register abandons the matrix in progress;
//          writes are always taken (ready tied high).
//   elem : one element per request, row-major. One element is taken per
//          cycle while the matrix is being read; each element only does a
//          compare against the running minimum and a count update in the
//          row chain (one cell, or every cell on a new strict minimum).
//   res  : after the last element, one request per row in row order, the
//          final one with last_row set. The counts leave through the cell
//          chain, one row per cycle while the receiver takes them, into
//          one output register stage. Elements are held off while rows
//          drain; the next matrix may start while the final result still
//          waits in the output register.
//   A stalled receiver holds the output register and freezes the chain.
//   Reset: num_rows = num_cols = 1, minimum at the largest positive value,
//   all counts zero, no result pending.
// ----------------------------------------------------------------------------
module row_count_of_matrix_minimum_unit #(
    parameter int MAX_ROWS = rcmm_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = rcmm_pkg::DEF_MAX_COLS
) (
    input  logic          clk,
    input  logic          rst_n,
    rcmm_cfg_if.sink      cfg,
    rcmm_elem_if.sink     elem,
    rcmm_result_if.source res
);

    localparam int CW       = rcmm_pkg::CFG_DATA_W;
    localparam int COLS_CAP = (MAX_COLS > 127) ? 127 : MAX_COLS;
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W    = (COLS_CAP > 1) ? $clog2(COLS_CAP) : 1;

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'b01,
        ST_DRAIN  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]                      num_rows_reg, num_rows_next;
    logic [CW-1:0]                      num_cols_reg, num_cols_next;
    logic signed [rcmm_pkg::ELEM_W-1:0] min_reg, min_next;
    logic [ROW_W-1:0]                   row_reg, row_next;
    logic [COL_W-1:0]                   col_reg, col_next;
    logic [ROW_W-1:0]                   drain_reg, drain_next;

    logic                               out_valid_reg, out_valid_next;
    logic [rcmm_pkg::ROW_IDX_W-1:0]     out_row_reg, out_row_next;
    logic [rcmm_pkg::COUNT_W-1:0]       out_count_reg, out_count_next;
    logic                               out_last_reg, out_last_next;

    logic [CW-1:0] rows_last;
    logic [CW-1:0] cols_last;
    logic          cfg_wr;
    logic          cfg_hit;
    logic          take;
    logic          is_less;
    logic          is_equal;
    logic          col_end;
    logic          row_end;
    logic          load;
    logic          drain_end;

    rcmm_pkg::cell_ctrl_t ctrl;

    logic [rcmm_pkg::COUNT_W-1:0] chain [MAX_ROWS+1];

    // effective sizes, zero taken as one and large values capped
    always_comb
    begin
        if (num_rows_reg == '0)
        begin
            rows_last = '0;
        end
        else if (num_rows_reg > CW'(MAX_ROWS))
        begin
            rows_last = CW'(MAX_ROWS - 1);
        end
        else
        begin
            rows_last = num_rows_reg - CW'(1);
        end

        if (num_cols_reg == '0)
        begin
            cols_last = '0;
        end
        else if (num_cols_reg > CW'(COLS_CAP))
        begin
            cols_last = CW'(COLS_CAP - 1);
        end
        else
        begin
            cols_last = num_cols_reg - CW'(1);
        end
    end

    // handshakes
    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    assign cfg_hit   = cfg_wr && ((cfg.index == rcmm_pkg::REG_NUM_ROWS) ||
                                  (cfg.index == rcmm_pkg::REG_NUM_COLS));

    assign elem.ready = (state_reg == ST_ACCEPT);
    assign take       = elem.valid && elem.ready;

    assign is_less  = take && (elem.element_value < min_reg);
    assign is_equal = take && (elem.element_value == min_reg);

    assign col_end = (CW'(col_reg) == cols_last);
    assign row_end = (CW'(row_reg) == rows_last);

    assign load      = (state_reg == ST_DRAIN) && (!out_valid_reg || res.ready);
    assign drain_end = load && (CW'(drain_reg) == rows_last);

    // cell control
    always_comb
    begin
        ctrl.clear = cfg_hit || drain_end;
        ctrl.shift = load;
        ctrl.less  = is_less;
        ctrl.equal = is_equal;
        ctrl.row   = rcmm_pkg::ROW_IDX_W'(row_reg);
    end

    // row of count cells, drained towards cell 0
    assign chain[MAX_ROWS] = '0;

    for (genvar g = 0; g < MAX_ROWS; g++)
    begin : g_cell
        rcmm_cell #(
            .IDX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .count_in  (chain[g+1]),
            .count_out (chain[g])
        );
    end

    // sequencing of position, minimum and drain
    always_comb
    begin
        state_next     = state_reg;
        num_rows_next  = num_rows_reg;
        num_cols_next  = num_cols_reg;
        min_next       = min_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        drain_next     = drain_reg;
        out_valid_next = out_valid_reg;
        out_row_next   = out_row_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;

        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_ACCEPT:
            begin
                if (take)
                begin
                    if (is_less)
                    begin
                        min_next = elem.element_value;
                    end
                    if (col_end)
                    begin
                        col_next = '0;
                        if (row_end)
                        begin
                            row_next   = '0;
                            drain_next = '0;
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            row_next = row_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = rcmm_pkg::ROW_IDX_W'(drain_reg);
                    out_count_next = chain[0];
                    out_last_next  = drain_end;
                    drain_next     = drain_reg + ROW_W'(1);
                    if (drain_end)
                    begin
                        min_next   = rcmm_pkg::MIN_RESET;
                        state_next = ST_ACCEPT;
                    end
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase

        // writes to known registers restart the matrix
        if (cfg_wr && (cfg.index == rcmm_pkg::REG_NUM_ROWS))
        begin
            num_rows_next = cfg.data;
        end
        if (cfg_wr && (cfg.index == rcmm_pkg::REG_NUM_COLS))
        begin
            num_cols_next = cfg.data;
        end
        if (cfg_hit)
        begin
            min_next   = rcmm_pkg::MIN_RESET;
            row_next   = '0;
            col_next   = '0;
            state_next = ST_ACCEPT;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCEPT;
            num_rows_reg  <= CW'(1);
            num_cols_reg  <= CW'(1);
            min_reg       <= rcmm_pkg::MIN_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            num_rows_reg  <= num_rows_next;
            num_cols_reg  <= num_cols_next;
            min_reg       <= min_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_row_reg   <= out_row_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    assign res.valid     = out_valid_reg;
    assign res.row_index = out_row_reg;
    assign res.min_count = out_count_reg;
    assign res.last_row  = out_last_reg;

endmodule

[verif/row_count_of_matrix_minimum_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// row_count_of_matrix_minimum_unit_tb: self-checking bench for the row count
// of the matrix minimum
// Streams signed matrices through the element channel under varied sizes,
// keeps its own running minimum and per-row counts, and compares every
// per-row count request against the counts predicted for that matrix.
// Register writes happen between matrices and part way through one, with
// random idle gaps on the element side and back-pressure on the result side.
// ----------------------------------------------------------------------------

// one per-row count as it should leave the block
typedef struct {
    logic [rcmm_pkg::ROW_IDX_W-1:0] row_index;
    logic [rcmm_pkg::COUNT_W-1:0]   min_count;
    logic                           last_row;
} row_count_t;

// running minimum, per-row counts and the counts awaited from the block
class row_min_tracker;
    logic [rcmm_pkg::CFG_DATA_W-1:0]    rows_raw;
    logic [rcmm_pkg::CFG_DATA_W-1:0]    cols_raw;
    logic signed [rcmm_pkg::ELEM_W-1:0] running_min;
    logic [rcmm_pkg::COUNT_W-1:0]       row_counts [rcmm_pkg::DEF_MAX_ROWS];
    int unsigned                        row_pos;
    int unsigned                        col_pos;
    row_count_t                         awaited_counts [$];
    int unsigned                        mismatches;

    function new();
        rows_raw   = 7'd1;
        cols_raw   = 7'd1;
        mismatches = 0;
        restart_matrix();
    endfunction

    function void restart_matrix();
        running_min = rcmm_pkg::MIN_RESET;
        foreach (row_counts[r])
            row_counts[r] = '0;
        row_pos = 0;
        col_pos = 0;
    endfunction

    // zero reads as one, anything above the limit as the limit
    function int unsigned used_size(logic [rcmm_pkg::CFG_DATA_W-1:0] raw,
                                    int unsigned limit);
        if (raw == 0)
            return 1;
        if (raw > limit)
            return limit;
        return raw;
    endfunction

    function int unsigned matrix_len();
        return used_size(rows_raw, rcmm_pkg::DEF_MAX_ROWS)
             * used_size(cols_raw, rcmm_pkg::DEF_MAX_COLS);
    endfunction

    // a write to a known register drops the matrix in progress
    function void take_register(logic [rcmm_pkg::CFG_IDX_W-1:0] idx,
                                logic [rcmm_pkg::CFG_DATA_W-1:0] data);
        if (idx == rcmm_pkg::REG_NUM_ROWS)
        begin
            rows_raw = data;
            restart_matrix();
        end
        else if (idx == rcmm_pkg::REG_NUM_COLS)
        begin
            cols_raw = data;
            restart_matrix();
        end
    endfunction

    function void take_element(logic signed [rcmm_pkg::ELEM_W-1:0] value);
        int unsigned nr;
        int unsigned nc;
        row_count_t  entry;
        nr = used_size(rows_raw, rcmm_pkg::DEF_MAX_ROWS);
        nc = used_size(cols_raw, rcmm_pkg::DEF_MAX_COLS);
        if (row_pos >= nr)
            row_pos = nr - 1;
        if (col_pos >= nc)
            col_pos = nc - 1;

        // new strict minimum restarts all counts, an equal one adds to this row
        if (value < running_min)
        begin
            running_min = value;
            foreach (row_counts[r])
                row_counts[r] = '0;
            row_counts[row_pos] = 7'd1;
        end
        else if (value == running_min && row_counts[row_pos] != rcmm_pkg::COUNT_MAX)
        begin
            row_counts[row_pos] = row_counts[row_pos] + 7'd1;
        end

        col_pos++;
        if (col_pos < nc)
            return;
        col_pos = 0;
        row_pos++;
        if (row_pos < nr)
            return;

        // matrix complete: one count per row, final row marked
        for (int unsigned r = 0; r < nr; r++)
        begin
            entry.row_index = r[rcmm_pkg::ROW_IDX_W-1:0];
            entry.min_count = row_counts[r];
            entry.last_row  = (r + 1 == nr);
            awaited_counts.push_back(entry);
        end
        restart_matrix();
    endfunction

    function void check_count(logic [rcmm_pkg::ROW_IDX_W-1:0] row_index,
                              logic [rcmm_pkg::COUNT_W-1:0]   min_count,
                              logic                           last_row);
        row_count_t want;
        if (awaited_counts.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected count request: row %0d count %0d last %0b",
                         row_index, min_count, last_row);
            return;
        end
        want = awaited_counts.pop_front();
        if (want.row_index !== row_index || want.min_count !== min_count
            || want.last_row !== last_row)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("count mismatch: expected row %0d count %0d last %0b, ",
                         want.row_index, want.min_count, want.last_row,
                         "got row %0d count %0d last %0b",
                         row_index, min_count, last_row);
        end
    endfunction
endclass

module row_count_of_matrix_minimum_unit_tb;

    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 300000;

    logic        clk;
    logic        rst_n;
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned cycles;

    row_min_tracker board = new();

    rcmm_cfg_if    cfg ();
    rcmm_elem_if   elem ();
    rcmm_result_if res ();

    row_count_of_matrix_minimum_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .elem  (elem),
        .res   (res)
    );

    // clock
    always #6 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("row_count_of_matrix_minimum_unit verification failed");
            $finish;
        end
    end

    // result side: check accepted requests, random back-pressure
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            board.check_count(res.row_index, res.min_count, res.last_row);
        res.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // one element request, valid left high for a following element
    task automatic send_element(input logic signed [rcmm_pkg::ELEM_W-1:0] value);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            elem.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct);
        end
        elem.valid         <= 1'b1;
        elem.element_value <= value;
        do
            @(posedge clk);
        while (!elem.ready);
        board.take_element(value);
    endtask

    // one register write, valid left high for a following write
    task automatic write_register(input logic [rcmm_pkg::CFG_IDX_W-1:0]  idx,
                                  input logic [rcmm_pkg::CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        board.take_register(idx, data);
    endtask

    // hold elements back until every awaited count is in, then let the block settle
    task automatic settle();
        elem.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.awaited_counts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly small sizes, sometimes zero, the limit or beyond it
    function automatic logic [rcmm_pkg::CFG_DATA_W-1:0] pick_size();
        case ($urandom_range(0, 19))
            0:       return 7'd0;
            1:       return 7'd127;
            2:       return 7'd64;
            3:       return 7'($urandom_range(65, 126));
            default: return 7'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic signed [rcmm_pkg::ELEM_W-1:0] pick_base();
        case ($urandom_range(0, 3))
            0:       return 32'sh7FFF_FFFD;
            1:       return 32'sh8000_0000;
            default: return $signed($urandom());
        endcase
    endfunction

    // values clustered near a base so that equal minima are common
    function automatic logic signed [rcmm_pkg::ELEM_W-1:0] pick_element(
        input logic signed [rcmm_pkg::ELEM_W-1:0] base);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return base + $signed(32'($urandom_range(0, 2)));
            6:                return rcmm_pkg::MIN_RESET;
            7:                return 32'sh8000_0000;
            default:          return $signed($urandom());
        endcase
    endfunction

    // random matrices under a series of sizes, with register writes mid-matrix
    task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct,
                             input int unsigned budget,
                             input logic [rcmm_pkg::CFG_DATA_W-1:0] first_rows,
                             input logic [rcmm_pkg::CFG_DATA_W-1:0] first_cols);
        int unsigned                        sent;
        int unsigned                        total;
        int unsigned                        e;
        bit                                 first;
        logic [rcmm_pkg::CFG_DATA_W-1:0]    rows_data;
        logic [rcmm_pkg::CFG_DATA_W-1:0]    cols_data;
        logic signed [rcmm_pkg::ELEM_W-1:0] base;
        sent  = 0;
        first = 1'b1;
        settle();
        src_idle_pct  = src_pct;
        sink_idle_pct = snk_pct;
        while (sent < budget)
        begin
            settle();
            if (first)
            begin
                rows_data = first_rows;
                cols_data = first_cols;
            end
            else
            begin
                rows_data = pick_size();
                cols_data = pick_size();
                // keep large by large rare
                if (board.used_size(rows_data, rcmm_pkg::DEF_MAX_ROWS) > 8
                    && board.used_size(cols_data, rcmm_pkg::DEF_MAX_COLS) > 8)
                    cols_data = 7'($urandom_range(1, 4));
            end
            if (first || $urandom_range(0, 3) != 0)
                write_register(rcmm_pkg::REG_NUM_ROWS, rows_data);
            if (first || $urandom_range(0, 3) != 0)
                write_register(rcmm_pkg::REG_NUM_COLS, cols_data);
            cfg.valid <= 1'b0;
            first = 1'b0;

            repeat ($urandom_range(1, 3))
            begin
                total = board.matrix_len();
                base  = pick_base();
                e     = 0;
                while (e < total && sent < budget)
                begin
                    // occasional write part way through a matrix
                    if (e != 0 && $urandom_range(0, 39) == 0)
                    begin
                        settle();
                        if ($urandom_range(0, 1) != 0)
                        begin
                            write_register(8'($urandom_range(2, 255)),
                                           7'($urandom_range(0, 127)));
                        end
                        else
                        begin
                            write_register(rcmm_pkg::REG_NUM_COLS, board.cols_raw);
                            e = 0;
                        end
                        cfg.valid <= 1'b0;
                    end
                    send_element(pick_element(base));
                    e++;
                    sent++;
                end
            end
        end
    endtask

    // stimulus
    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        cycles             = 0;
        src_idle_pct       = 15;
        sink_idle_pct      = 60;
        cfg.valid          = 1'b0;
        cfg.index          = '0;
        cfg.data           = '0;
        elem.valid         = 1'b0;
        elem.element_value = '0;
        res.ready          = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size one by one: largest, smallest, zero, minus one
        send_element(rcmm_pkg::MIN_RESET);
        send_element(32'sh8000_0000);
        send_element(32'sd0);
        send_element(-32'sd1);

        settle();
        write_register(rcmm_pkg::REG_NUM_ROWS, 7'd2);
        write_register(rcmm_pkg::REG_NUM_COLS, 7'd2);
        cfg.valid <= 1'b0;

        // matrix of only the largest value
        repeat (4) send_element(rcmm_pkg::MIN_RESET);

        // late strict minimum, then minimum repeated across rows
        send_element(32'sd5);
        send_element(32'sd5);
        send_element(32'sd5);
        send_element(32'sd3);
        send_element(32'sd7);
        send_element(-32'sd7);
        send_element(-32'sd7);
        send_element(-32'sd7);

        // unknown register mid-matrix keeps the matrix
        send_element(32'sd9);
        send_element(32'sd4);
        settle();
        write_register(8'hA5, 7'h55);
        cfg.valid <= 1'b0;
        send_element(32'sd4);
        send_element(32'sd1);

        // known register mid-matrix drops it
        send_element(32'sd6);
        settle();
        write_register(rcmm_pkg::REG_NUM_ROWS, 7'd2);
        cfg.valid <= 1'b0;
        repeat (4) send_element(32'sd3);

        run_phase(15, 60, 170, 7'd0, 7'd127);
        run_phase(60, 15, 170, 7'd127, 7'd0);
        run_phase(0, 0, 170, 7'd1, 7'd64);

        settle();
        if (board.mismatches == 0 && board.awaited_counts.size() == 0)
            $display("row_count_of_matrix_minimum_unit verification clean");
        else
            $display("row_count_of_matrix_minimum_unit verification failed");
        $finish;
    end

endmodule

[row_count_of_matrix_minimum_unit.f]
rtl/rcmm_pkg.sv
rtl/rcmm_if.sv
rtl/rcmm_cell.sv
rtl/row_count_of_matrix_minimum_unit.sv
verif/row_count_of_matrix_minimum_unit_tb.sv
